@@ rtl/nfr_pkg.sv @@
// Package for the newest-first ring store with id lookup.
// Holds request codes, controller state type and default sizes.
// No dependencies.
package nfr_pkg;

  localparam int unsigned DefCapacity = 8;
  localparam int unsigned IdW         = 8;
  localparam int unsigned PayW        = 32;
  localparam int unsigned ReqW        = 3;

  localparam logic [ReqW-1:0] REQ_PUSH    = 3'd0;
  localparam logic [ReqW-1:0] REQ_LATEST  = 3'd1;
  localparam logic [ReqW-1:0] REQ_BY_ID   = 3'd2;
  localparam logic [ReqW-1:0] REQ_NEWER   = 3'd3;
  localparam logic [ReqW-1:0] REQ_OLDER   = 3'd4;
  localparam logic [ReqW-1:0] REQ_DISMISS = 3'd5;
  localparam logic [ReqW-1:0] REQ_CLEAR   = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SHRD = 5'b00100,
    S_SHWR = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

@@ rtl/nfr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/newest_first_ring_with_id_lookup_top.sv @@
// Newest-first ring store with id lookup; ids in flops, payloads in nfr_ram.
// Depends on nfr_pkg and nfr_ram.
// Push, miss and clear go from idle straight to S_OUT; hit lookups pass through S_LOAD (RAM read).
// Dismiss of a non-front entry closes the gap, moving each payload word via S_SHRD then S_SHWR.
// One request at a time; the next waits until the result word has been taken.
// Reset (async, active low) empties the store and clears id counter and flag.
module newest_first_ring_with_id_lookup_top #(
  parameter int unsigned CAPACITY = nfr_pkg::DefCapacity,
  localparam int unsigned IDX_W   = $clog2(CAPACITY),
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [nfr_pkg::ReqW-1:0] req_type_i,
  input  logic [nfr_pkg::IdW-1:0]  entry_id_i,
  input  logic [nfr_pkg::PayW-1:0] payload_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [nfr_pkg::IdW-1:0]  out_id_o,
  output logic [nfr_pkg::PayW-1:0] out_payload_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     new_flag_o
);

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] front,
                                            input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, front} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  nfr_pkg::state_e state_q, state_d;

  logic [nfr_pkg::IdW-1:0]  ids_q [CAPACITY];
  logic [nfr_pkg::IdW-1:0]  ids_d [CAPACITY];
  logic [IDX_W-1:0]         front_q, front_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [nfr_pkg::IdW-1:0]  last_id_q, last_id_d;
  logic                     flag_q, flag_d;
  logic [IDX_W-1:0]         shpos_q, shpos_d;

  logic                     found_q, found_d;
  logic [nfr_pkg::IdW-1:0]  oid_q, oid_d;
  logic [nfr_pkg::PayW-1:0] opay_q, opay_d;
  logic [CNT_W-1:0]         ocnt_q, ocnt_d;
  logic                     oflag_q, oflag_d;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [nfr_pkg::PayW-1:0] ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [nfr_pkg::PayW-1:0] ram_rdata;

  logic                     hit;
  logic [IDX_W-1:0]         hit_pos;
  logic                     have;
  logic [IDX_W-1:0]         have_pos;
  logic [IDX_W-1:0]         front_dec;
  logic [IDX_W-1:0]         front_inc;
  logic                     in_fire;

  nfr_ram #(
    .WIDTH(nfr_pkg::PayW),
    .DEPTH(CAPACITY)
  ) u_pay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o    = (state_q == nfr_pkg::S_IDLE);
  assign in_fire       = in_valid_i & in_ready_o;
  assign out_valid_o   = (state_q == nfr_pkg::S_OUT);
  assign found_o       = found_q;
  assign out_id_o      = oid_q;
  assign out_payload_o = opay_q;
  assign count_o       = ocnt_q;
  assign new_flag_o    = oflag_q;

  assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
  assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + IDX_W'(1);

  // Newest match wins: scan from the oldest position so the lowest one sticks.
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int p = CAPACITY - 1; p >= 0; p--) begin
      if (CNT_W'(p) < count_q && ids_q[slot(front_q, IDX_W'(p))] == entry_id_i) begin
        hit     = 1'b1;
        hit_pos = IDX_W'(p);
      end
    end
  end

  always_comb begin
    have     = 1'b0;
    have_pos = '0;
    case (req_type_i)
      nfr_pkg::REQ_LATEST: begin
        have = (count_q != '0);
      end
      nfr_pkg::REQ_BY_ID: begin
        have     = hit;
        have_pos = hit_pos;
      end
      nfr_pkg::REQ_NEWER: begin
        have     = hit && (hit_pos != '0);
        have_pos = hit_pos - IDX_W'(1);
      end
      nfr_pkg::REQ_OLDER: begin
        have     = hit && (CNT_W'(hit_pos) + CNT_W'(1) < count_q);
        have_pos = hit_pos + IDX_W'(1);
      end
      default: begin
        have = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic [IDX_W:0]   rel;
    logic [IDX_W-1:0] ppos;
    logic [IDX_W-1:0] nxt;

    rel       = '0;
    ppos      = '0;
    nxt       = '0;
    state_d   = state_q;
    ids_d     = ids_q;
    front_d   = front_q;
    count_d   = count_q;
    last_id_d = last_id_q;
    flag_d    = flag_q;
    shpos_d   = shpos_q;
    found_d   = found_q;
    oid_d     = oid_q;
    opay_d    = opay_q;
    ocnt_d    = ocnt_q;
    oflag_d   = oflag_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = payload_i;
    ram_raddr = slot(front_q, have_pos);

    unique case (state_q)
      nfr_pkg::S_IDLE: begin
        if (in_fire) begin
          found_d = 1'b0;
          oid_d   = '0;
          opay_d  = '0;
          state_d = nfr_pkg::S_OUT;
          case (req_type_i)
            nfr_pkg::REQ_PUSH: begin
              last_id_d        = last_id_q + nfr_pkg::IdW'(1);
              flag_d           = 1'b1;
              front_d          = front_dec;
              ids_d[front_dec] = last_id_d;
              ram_we           = 1'b1;
              ram_waddr        = front_dec;
              if (count_q < CNT_W'(CAPACITY)) begin
                count_d = count_q + CNT_W'(1);
              end
              found_d = 1'b1;
              oid_d   = last_id_d;
              opay_d  = payload_i;
            end
            nfr_pkg::REQ_LATEST, nfr_pkg::REQ_BY_ID,
            nfr_pkg::REQ_NEWER, nfr_pkg::REQ_OLDER: begin
              if (have) begin
                found_d = 1'b1;
                oid_d   = ids_q[slot(front_q, have_pos)];
                state_d = nfr_pkg::S_LOAD;
              end
            end
            nfr_pkg::REQ_DISMISS: begin
              if (hit) begin
                found_d = 1'b1;
                oid_d   = entry_id_i;
                count_d = count_q - CNT_W'(1);
                if (hit_pos == '0) begin
                  front_d = front_inc;
                end else begin
                  // Ids close up at once; payload words follow one per step.
                  for (int s = 0; s < CAPACITY; s++) begin
                    rel = (IDX_W+1)'(s) + (IDX_W+1)'(CAPACITY) - {1'b0, front_q};
                    if (rel >= (IDX_W+1)'(CAPACITY)) begin
                      rel = rel - (IDX_W+1)'(CAPACITY);
                    end
                    ppos = rel[IDX_W-1:0];
                    nxt  = (s == CAPACITY - 1) ? '0 : IDX_W'(s + 1);
                    if (ppos >= hit_pos && CNT_W'(ppos) + CNT_W'(1) < count_q) begin
                      ids_d[s] = ids_q[nxt];
                    end
                  end
                  if (CNT_W'(hit_pos) < count_d) begin
                    shpos_d = hit_pos;
                    state_d = nfr_pkg::S_SHRD;
                  end
                end
              end
            end
            nfr_pkg::REQ_CLEAR: begin
              found_d = 1'b1;
              flag_d  = 1'b0;
            end
            default: begin
              found_d = 1'b0;
            end
          endcase
          ocnt_d  = count_d;
          oflag_d = (req_type_i == nfr_pkg::REQ_CLEAR) ? flag_q : flag_d;
        end
      end
      nfr_pkg::S_LOAD: begin
        opay_d  = ram_rdata;
        state_d = nfr_pkg::S_OUT;
      end
      nfr_pkg::S_SHRD: begin
        ram_raddr = slot(front_q, shpos_q + IDX_W'(1));
        state_d   = nfr_pkg::S_SHWR;
      end
      nfr_pkg::S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = slot(front_q, shpos_q);
        ram_wdata = ram_rdata;
        shpos_d   = shpos_q + IDX_W'(1);
        // count_q already holds the reduced count here.
        if (CNT_W'(shpos_q) + CNT_W'(1) < count_q) begin
          state_d = nfr_pkg::S_SHRD;
        end else begin
          state_d = nfr_pkg::S_OUT;
        end
      end
      nfr_pkg::S_OUT: begin
        if (out_ready_i) begin
          state_d = nfr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nfr_pkg::S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      last_id_q <= '0;
      flag_q    <= 1'b0;
      shpos_q   <= '0;
      for (int s = 0; s < CAPACITY; s++) begin
        ids_q[s] <= '0;
      end
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      last_id_q <= last_id_d;
      flag_q    <= flag_d;
      shpos_q   <= shpos_d;
      ids_q     <= ids_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    oid_q   <= oid_d;
    opay_q  <= opay_d;
    ocnt_q  <= ocnt_d;
    oflag_q <= oflag_d;
  end

endmodule
